@@ rtl/core/sdg_pkg.sv @@
// Package for the step/direction generator: widths, reset values, command
// and register codes shared by the top level and its serial arithmetic units.
// Depends on nothing.
`default_nettype none

package sdg_pkg;

   localparam int POSITION_WIDTH_DEF = 32;
   localparam int FRACTION_BITS_DEF  = 8;

   // Shift-add multiplier: 32-bit operand times the 16-bit steps per mm.
   localparam int MUL_A_W = 32;
   localparam int MUL_B_W = 16;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Restoring divider with a constant dividend of one minute in microseconds.
   localparam int              DIV_DVD_W     = 26;
   localparam int              DIV_D_W       = 32;
   localparam int              DIV_Q_W       = 32;
   localparam [DIV_DVD_W-1:0]  US_PER_MINUTE = 26'd60000000;

   localparam int             CSR_INDEX_W        = 1;
   localparam int             CSR_DATA_W         = 16;
   localparam [CSR_DATA_W-1:0] STEPS_PER_MM_RESET = 16'd80;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEPS_PER_MM = 1'b0,
      CSR_INVERT_DIR   = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      CMD_TICK      = 3'd0,
      CMD_FORWARD   = 3'd1,
      CMD_BACKWARD  = 3'd2,
      CMD_MOVE_TO   = 3'd3,
      CMD_SET_COORD = 3'd4
   } cmd_type;

endpackage

`default_nettype wire

@@ rtl/core/sdg_mul.sv @@
// Bit-serial shift-add multiplier, one multiplier bit per cycle.
// Depends on sdg_pkg for the operand widths.
`default_nettype none

module sdg_mul (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [sdg_pkg::MUL_A_W-1:0] a,
   input  wire logic [sdg_pkg::MUL_B_W-1:0] b,
   output logic                             done,
   output logic      [sdg_pkg::MUL_P_W-1:0] product
);
   import sdg_pkg::*;

   localparam int CNT_W = $clog2(MUL_B_W + 1);

   logic [MUL_P_W-1:0] acc_ff, acc_in;
   logic [MUL_P_W-1:0] mcand_ff, mcand_in;
   logic [MUL_B_W-1:0] mplier_ff, mplier_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               done_ff, done_in;

   always_comb begin
      acc_in    = acc_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (start) begin
         acc_in    = '0;
         mcand_in  = MUL_P_W'(a);
         mplier_in = b;
         cnt_in    = CNT_W'(MUL_B_W);
      end else if (cnt_ff != '0) begin
         if (mplier_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in  = {mcand_ff[MUL_P_W-2:0], 1'b0};
         mplier_in = {1'b0, mplier_ff[MUL_B_W-1:1]};
         cnt_in    = cnt_ff - CNT_W'(1);
         done_in   = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

@@ rtl/core/sdg_div.sv @@
// Restoring divider for the step interval: one minute in microseconds over
// a 32-bit divisor, one quotient bit per cycle. Depends on sdg_pkg.
`default_nettype none

module sdg_div (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   input  wire logic [sdg_pkg::DIV_D_W-1:0] divisor,
   output logic                             done,
   output logic      [sdg_pkg::DIV_Q_W-1:0] quotient
);
   import sdg_pkg::*;

   localparam int CNT_W = $clog2(DIV_DVD_W + 1);

   logic [DIV_D_W-1:0]   rem_ff, rem_in;
   logic [DIV_D_W-1:0]   dvs_ff, dvs_in;
   logic [DIV_DVD_W-1:0] dvd_ff, dvd_in;
   logic [DIV_DVD_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [DIV_D_W:0]     trial;
   logic [DIV_D_W:0]     diff;
   logic                 ge;

   always_comb begin
      trial     = {rem_ff, dvd_ff[DIV_DVD_W-1]};
      diff      = trial - {1'b0, dvs_ff};
      ge        = (trial >= {1'b0, dvs_ff});
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      dvd_in    = dvd_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      done_in   = 1'b0;
      if (start) begin
         rem_in = '0;
         dvs_in = divisor;
         dvd_in = US_PER_MINUTE;
         quo_in = '0;
         cnt_in = CNT_W'(DIV_DVD_W);
      end else if (cnt_ff != '0) begin
         // The partial remainder stays below the divisor, so it fits 32 bits.
         rem_in  = ge ? diff[DIV_D_W-1:0] : trial[DIV_D_W-1:0];
         quo_in  = {quo_ff[DIV_DVD_W-2:0], ge};
         dvd_in  = {dvd_ff[DIV_DVD_W-2:0], 1'b0};
         cnt_in  = cnt_ff - CNT_W'(1);
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = DIV_Q_W'(quo_ff);

endmodule

`default_nettype wire

@@ rtl/core/stepper_step_dir_generator.sv @@
// Step/direction generator for one stepper axis: top level with the command
// sequencer and axis state. Depends on sdg_pkg, sdg_mul and sdg_div.
//
// One transaction is taken at a time and gives exactly one response. A
// tick, a refused move and an unused code go straight to the commit. A
// set-coordinate runs the 16-step serial scaling multiply, then forms the
// new offset through the difference and sum states. A forward or backward
// move runs the serial feedrate times steps-per-mm product and the 26-step
// bit-serial interval division between the accept and the commit. A move to
// position first scales the position through the same multiplier, and the
// difference is formed over three more states (difference, sum, saturate)
// before the product and the division. A move to position whose difference
// is zero stops after the saturate state. A new transaction is accepted while
// the previous response still waits in the output register, but it cannot
// complete until that response has been taken.
`default_nettype none

module stepper_step_dir_generator #(
   parameter int POSITION_WIDTH = sdg_pkg::POSITION_WIDTH_DEF,
   parameter int FRACTION_BITS  = sdg_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [2:0]                      req_cmd,
   input  wire logic [31:0]                     req_pulse_count,
   input  wire logic [15:0]                     req_feedrate,
   input  wire logic signed [31:0]              req_position_mm,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic                                 rsp_step_pulse,
   output logic                                 rsp_direction,
   output logic                                 rsp_moving,
   output logic signed [31:0]                   rsp_position_steps,
   output logic                                 rsp_rejected,
   input  wire logic                            csr_we,
   input  wire logic [sdg_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [sdg_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import sdg_pkg::*;

   localparam int PW  = POSITION_WIDTH;
   localparam int D_W = ((PW > MUL_P_W) ? PW : MUL_P_W) + 2;

   typedef enum logic [2:0] {
      S_IDLE, S_SCALE, S_DIFF, S_SUM, S_SAT, S_PROD, S_DIV, S_DONE
   } state_type;

   state_type state_ff, state_in;

   logic [CSR_DATA_W-1:0] spm_ff, spm_in;
   logic                  inv_ff, inv_in;

   logic [2:0]   cmd_ff, cmd_in;
   logic [31:0]  count_ff, count_in;
   logic [15:0]  feed_ff, feed_in;
   logic         pos_neg_ff, pos_neg_in;
   logic         rej_ff, rej_in;
   logic         move_ff, move_in;
   logic         fwd_new_ff, fwd_new_in;
   logic [D_W-1:0] scaled_ff, scaled_in;
   logic [D_W-1:0] diff_ff, diff_in;
   logic [PW-1:0]  off_new_ff, off_new_in;
   logic [31:0]    interval_new_ff, interval_new_in;

   logic [31:0]   step_interval_ff, step_interval_in;
   logic [31:0]   wait_count_ff, wait_count_in;
   logic [31:0]   steps_left_ff, steps_left_in;
   logic          busy_ff, busy_in;
   logic          forward_dir_ff, forward_dir_in;
   logic [PW-1:0] abs_pos_ff, abs_pos_in;
   logic [PW-1:0] coord_off_ff, coord_off_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_pulse_ff, rsp_pulse_in;
   logic          rsp_dir_ff, rsp_dir_in;
   logic          rsp_moving_ff, rsp_moving_in;
   logic [31:0]   rsp_pos_ff, rsp_pos_in;
   logic          rsp_rej_ff, rsp_rej_in;

   logic               mul_start_ff, mul_start_in;
   logic [MUL_A_W-1:0] mul_a_ff, mul_a_in;
   logic               mul_done;
   logic [MUL_P_W-1:0] mul_product;
   logic               div_start_ff, div_start_in;
   logic [DIV_D_W-1:0] div_divisor_ff, div_divisor_in;
   logic               div_done;
   logic [DIV_Q_W-1:0] div_quotient;

   logic [31:0]    pos_raw;
   logic [31:0]    pos_mag;
   logic [D_W-1:0] scale_mag;
   logic [D_W-1:0] abs_ext;
   logic [D_W-1:0] off_ext;
   logic [D_W-1:0] d_mag;
   logic [31:0]    wait_inc;
   logic           issue;
   logic           commit;

   sdg_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start_ff),
      .a       (mul_a_ff),
      .b       (spm_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   sdg_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .divisor  (div_divisor_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   always_comb begin
      pos_raw   = req_position_mm;
      pos_mag   = pos_raw[31] ? (~pos_raw + 32'd1) : pos_raw;
      scale_mag = D_W'(mul_product >> FRACTION_BITS);
      abs_ext   = {{(D_W-PW){abs_pos_ff[PW-1]}}, abs_pos_ff};
      off_ext   = {{(D_W-PW){coord_off_ff[PW-1]}}, coord_off_ff};
      d_mag     = diff_ff[D_W-1] ? (~diff_ff + D_W'(1)) : diff_ff;
      wait_inc  = (wait_count_ff == '1) ? wait_count_ff : (wait_count_ff + 32'd1);
      issue     = busy_ff && (steps_left_ff != '0) && (wait_inc >= step_interval_ff);
      commit    = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

      state_in        = state_ff;
      spm_in          = spm_ff;
      inv_in          = inv_ff;
      cmd_in          = cmd_ff;
      count_in        = count_ff;
      feed_in         = feed_ff;
      pos_neg_in      = pos_neg_ff;
      rej_in          = rej_ff;
      move_in         = move_ff;
      fwd_new_in      = fwd_new_ff;
      scaled_in       = scaled_ff;
      diff_in         = diff_ff;
      off_new_in      = off_new_ff;
      interval_new_in = interval_new_ff;
      mul_start_in    = 1'b0;
      mul_a_in        = mul_a_ff;
      div_start_in    = 1'b0;
      div_divisor_in  = div_divisor_ff;

      step_interval_in = step_interval_ff;
      wait_count_in    = wait_count_ff;
      steps_left_in    = steps_left_ff;
      busy_in          = busy_ff;
      forward_dir_in   = forward_dir_ff;
      abs_pos_in       = abs_pos_ff;
      coord_off_in     = coord_off_ff;

      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_pulse_in  = rsp_pulse_ff;
      rsp_dir_in    = rsp_dir_ff;
      rsp_moving_in = rsp_moving_ff;
      rsp_pos_in    = rsp_pos_ff;
      rsp_rej_in    = rsp_rej_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_STEPS_PER_MM: spm_in = csr_wdata;
            CSR_INVERT_DIR:   inv_in = csr_wdata[0];
            default:          ;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in     = req_cmd;
               count_in   = req_pulse_count;
               feed_in    = req_feedrate;
               pos_neg_in = pos_raw[31];
               rej_in     = 1'b0;
               move_in    = 1'b0;
               state_in   = S_DONE;
               unique case (req_cmd) inside
                  CMD_FORWARD, CMD_BACKWARD, CMD_MOVE_TO: begin
                     if (req_feedrate == '0 || spm_ff == '0) begin
                        rej_in = 1'b1;
                     end else if (req_cmd == CMD_MOVE_TO) begin
                        mul_start_in = 1'b1;
                        mul_a_in     = pos_mag;
                        state_in     = S_SCALE;
                     end else begin
                        fwd_new_in   = (req_cmd == CMD_FORWARD);
                        move_in      = 1'b1;
                        mul_start_in = 1'b1;
                        mul_a_in     = MUL_A_W'(req_feedrate);
                        state_in     = S_PROD;
                     end
                  end
                  CMD_SET_COORD: begin
                     mul_start_in = 1'b1;
                     mul_a_in     = pos_mag;
                     state_in     = S_SCALE;
                  end
                  default: ;
               endcase
            end
         end
         S_SCALE: begin
            if (mul_done) begin
               scaled_in = pos_neg_ff ? (~scale_mag + D_W'(1)) : scale_mag;
               state_in  = S_DIFF;
            end
         end
         S_DIFF: begin
            diff_in  = (cmd_ff == CMD_SET_COORD) ? (abs_ext - scaled_ff)
                                                 : (scaled_ff - abs_ext);
            state_in = S_SUM;
         end
         S_SUM: begin
            if (cmd_ff == CMD_SET_COORD) begin
               off_new_in = diff_ff[PW-1:0];
               state_in   = S_DONE;
            end else begin
               diff_in  = diff_ff + off_ext;
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            // A zero difference leaves the axis alone.
            if (diff_ff == '0) begin
               state_in = S_DONE;
            end else begin
               fwd_new_in   = !diff_ff[D_W-1];
               count_in     = (d_mag[D_W-1:32] != '0) ? '1 : d_mag[31:0];
               move_in      = 1'b1;
               mul_start_in = 1'b1;
               mul_a_in     = MUL_A_W'(feed_ff);
               state_in     = S_PROD;
            end
         end
         S_PROD: begin
            if (mul_done) begin
               div_start_in   = 1'b1;
               div_divisor_in = mul_product[DIV_D_W-1:0];
               state_in       = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               interval_new_in = div_quotient;
               state_in        = S_DONE;
            end
         end
         S_DONE: begin
            if (commit) begin
               rsp_pulse_in = 1'b0;
               case (cmd_ff) inside
                  CMD_TICK: begin
                     if (issue) begin
                        rsp_pulse_in  = 1'b1;
                        wait_count_in = '0;
                        steps_left_in = steps_left_ff - 32'd1;
                        abs_pos_in    = forward_dir_ff ? (abs_pos_ff + PW'(1))
                                                       : (abs_pos_ff - PW'(1));
                     end else begin
                        wait_count_in = wait_inc;
                     end
                     busy_in = issue ? (steps_left_ff != 32'd1) : (steps_left_ff != '0);
                  end
                  CMD_FORWARD, CMD_BACKWARD, CMD_MOVE_TO: begin
                     if (move_ff) begin
                        forward_dir_in   = fwd_new_ff;
                        step_interval_in = interval_new_ff;
                        steps_left_in    = count_ff;
                        busy_in          = (count_ff != '0);
                     end
                  end
                  CMD_SET_COORD: coord_off_in = off_new_ff;
                  default: ;
               endcase
               rsp_valid_in  = 1'b1;
               rsp_dir_in    = forward_dir_in ^ inv_ff;
               rsp_moving_in = busy_in;
               rsp_pos_in    = 32'(abs_pos_in);
               rsp_rej_in    = rej_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      cmd_ff          <= cmd_in;
      count_ff        <= count_in;
      feed_ff         <= feed_in;
      pos_neg_ff      <= pos_neg_in;
      fwd_new_ff      <= fwd_new_in;
      scaled_ff       <= scaled_in;
      diff_ff         <= diff_in;
      off_new_ff      <= off_new_in;
      interval_new_ff <= interval_new_in;
      mul_a_ff        <= mul_a_in;
      div_divisor_ff  <= div_divisor_in;
      rsp_pulse_ff    <= rsp_pulse_in;
      rsp_dir_ff      <= rsp_dir_in;
      rsp_moving_ff   <= rsp_moving_in;
      rsp_pos_ff      <= rsp_pos_in;
      rsp_rej_ff      <= rsp_rej_in;
      if (reset) begin
         state_ff         <= S_IDLE;
         spm_ff           <= STEPS_PER_MM_RESET;
         inv_ff           <= 1'b0;
         rej_ff           <= 1'b0;
         move_ff          <= 1'b0;
         mul_start_ff     <= 1'b0;
         div_start_ff     <= 1'b0;
         step_interval_ff <= '0;
         wait_count_ff    <= '0;
         steps_left_ff    <= '0;
         busy_ff          <= 1'b0;
         forward_dir_ff   <= 1'b0;
         abs_pos_ff       <= '0;
         coord_off_ff     <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         spm_ff           <= spm_in;
         inv_ff           <= inv_in;
         rej_ff           <= rej_in;
         move_ff          <= move_in;
         mul_start_ff     <= mul_start_in;
         div_start_ff     <= div_start_in;
         step_interval_ff <= step_interval_in;
         wait_count_ff    <= wait_count_in;
         steps_left_ff    <= steps_left_in;
         busy_ff          <= busy_in;
         forward_dir_ff   <= forward_dir_in;
         abs_pos_ff       <= abs_pos_in;
         coord_off_ff     <= coord_off_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   assign req_ready          = (state_ff == S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_step_pulse     = rsp_pulse_ff;
   assign rsp_direction      = rsp_dir_ff;
   assign rsp_moving         = rsp_moving_ff;
   assign rsp_position_steps = rsp_pos_ff;
   assign rsp_rejected       = rsp_rej_ff;

endmodule

`default_nettype wire

@@ rtl/core/sdg_checker.sv @@
// Port-level checks for the step/direction generator, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module sdg_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic               rsp_step_pulse,
   input wire logic               rsp_direction,
   input wire logic               rsp_moving,
   input wire logic signed [31:0] rsp_position_steps,
   input wire logic               rsp_rejected
);

   logic [31:0] last_pos_ff, last_pos_in;
   logic        last_moving_ff, last_moving_in;
   logic [1:0]  outstanding_ff, outstanding_in;
   logic        req_fire;
   logic        rsp_fire;

   always_comb begin
      req_fire       = req_valid && req_ready;
      rsp_fire       = rsp_valid && rsp_ready;
      last_pos_in    = rsp_fire ? rsp_position_steps : last_pos_ff;
      last_moving_in = rsp_fire ? rsp_moving : last_moving_ff;
      outstanding_in = outstanding_ff + 2'(req_fire) - 2'(rsp_fire);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_pos_ff    <= '0;
         last_moving_ff <= 1'b0;
         outstanding_ff <= '0;
      end else begin
         last_pos_ff    <= last_pos_in;
         last_moving_ff <= last_moving_in;
         outstanding_ff <= outstanding_in;
      end
   end

   // A stalled response holds its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_step_pulse, rsp_direction,
         rsp_moving, rsp_position_steps, rsp_rejected}))
      else $error("response changed while stalled");

   // The position only moves on a response that reports a step.
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire && !rsp_step_pulse |-> rsp_position_steps == last_pos_ff)
      else $error("position changed without a step");

   // A step is only issued while the axis was moving.
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_step_pulse |-> last_moving_ff)
      else $error("step issued while idle");

   // A refused move leaves the motion state alone.
   assert property (@(posedge clock) disable iff (reset)
      rsp_fire && rsp_rejected |-> rsp_moving == last_moving_ff && !rsp_step_pulse)
      else $error("refused move changed the motion state");

   // Every response belongs to an accepted transaction.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> outstanding_ff != 2'd0)
      else $error("response without a transaction");

endmodule

bind stepper_step_dir_generator sdg_checker u_sdg_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_step_pulse     (rsp_step_pulse),
   .rsp_direction      (rsp_direction),
   .rsp_moving         (rsp_moving),
   .rsp_position_steps (rsp_position_steps),
   .rsp_rejected       (rsp_rejected)
);

`default_nettype wire

@@ bench/stepper_step_dir_generator_tb.sv @@
// Self-checking bench for the step/direction generator: directed commands, register
// extremes and random move traffic, each checked against an in-bench axis model.
// Depends on sdg_pkg and stepper_step_dir_generator.
`timescale 1ns / 1ps

module stepper_step_dir_generator_tb;
   import sdg_pkg::*;

   typedef longint unsigned u64_type;

   typedef struct packed {
      logic        step_pulse;
      logic        direction;
      logic        moving;
      logic [31:0] position_steps;
      logic        rejected;
   } axis_status_type;

   localparam int          RESET_CYCLES    = 5;
   localparam int          SETTLE_CYCLES   = 20;
   localparam int          TAIL_CYCLES     = 50;
   localparam int          WATCHDOG_CYCLES = 4000;
   localparam int          MAX_RUN_TICKS   = 40;
   localparam logic [2:0]  CMD_UNUSED_FIRST = 3'd5;
   localparam logic [2:0]  CMD_UNUSED_LAST  = 3'd7;
   localparam u64_type     MINUTE_US       = US_PER_MINUTE;
   localparam longint      MAX_STEPS       = 64'h0000_0000_FFFF_FFFF;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [2:0]             req_cmd = CMD_TICK;
   logic [31:0]            req_pulse_count = '0;
   logic [15:0]            req_feedrate = '0;
   logic signed [31:0]     req_position_mm = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic                   rsp_step_pulse;
   logic                   rsp_direction;
   logic                   rsp_moving;
   logic signed [31:0]     rsp_position_steps;
   logic                   rsp_rejected;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // Axis model state and its copy of the registers.
   logic [15:0] spm_cfg       = STEPS_PER_MM_RESET;
   logic        invert_cfg    = 1'b0;
   logic [31:0] interval_st   = '0;
   logic [31:0] wait_st       = '0;
   logic [31:0] steps_left_st = '0;
   logic        busy_st       = 1'b0;
   logic        fwd_st        = 1'b0;
   logic [31:0] abs_pos_st    = '0;
   logic [31:0] offset_st     = '0;

   axis_status_type axis_status_q[$];
   int              fail_count   = 0;
   int              items_sent   = 0;
   int              quiet_cycles = 0;
   int              stall_left   = 0;
   bit              idle_on      = 1'b0;

   stepper_step_dir_generator u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_pulse_count    (req_pulse_count),
      .req_feedrate       (req_feedrate),
      .req_position_mm    (req_position_mm),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_step_pulse     (rsp_step_pulse),
      .rsp_direction      (rsp_direction),
      .rsp_moving         (rsp_moving),
      .rsp_position_steps (rsp_position_steps),
      .rsp_rejected       (rsp_rejected),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Millimetres with fraction bits to steps, truncated toward zero.
   function automatic longint scale_mm(input logic [31:0] raw);
      longint mag;
      longint spm_l;
      spm_l = spm_cfg;
      mag = $signed(raw);
      if (mag < 0)
         mag = -mag;
      mag = (mag * spm_l) >>> FRACTION_BITS_DEF;
      return raw[31] ? -mag : mag;
   endfunction

   function automatic void load_move(input logic fwd, input logic [31:0] count,
                                     input logic [15:0] feed);
      u64_type prod;
      prod = feed;
      prod = prod * spm_cfg;
      fwd_st        = fwd;
      interval_st   = 32'(MINUTE_US / prod);
      steps_left_st = count;
      busy_st       = (count != 0);
   endfunction

   // Applies one command to the axis model and returns the status it reports.
   function automatic axis_status_type advance_axis(input logic [2:0] cmd,
                                                    input logic [31:0] count,
                                                    input logic [15:0] feed,
                                                    input logic [31:0] pos_mm);
      axis_status_type st;
      longint          cur;
      longint          off;
      longint          diff;
      longint          mag;
      st  = '0;
      cur = $signed(abs_pos_st);
      off = $signed(offset_st);
      case (cmd)
         CMD_TICK: begin
            if (wait_st != 32'hFFFF_FFFF)
               wait_st = wait_st + 1;
            if (busy_st && steps_left_st != 0 && wait_st >= interval_st) begin
               st.step_pulse = 1'b1;
               wait_st       = '0;
               steps_left_st = steps_left_st - 1;
               abs_pos_st    = fwd_st ? abs_pos_st + 1 : abs_pos_st - 1;
            end
            busy_st = (steps_left_st != 0);
         end
         CMD_FORWARD, CMD_BACKWARD, CMD_MOVE_TO: begin
            if (feed == 0 || spm_cfg == 0) begin
               st.rejected = 1'b1;
            end else if (cmd == CMD_MOVE_TO) begin
               diff = scale_mm(pos_mm) - cur + off;
               mag  = (diff < 0) ? -diff : diff;
               if (mag > MAX_STEPS)
                  mag = MAX_STEPS;
               if (diff != 0)
                  load_move(diff > 0, 32'(mag), feed);
            end else begin
               load_move(cmd == CMD_FORWARD, count, feed);
            end
         end
         CMD_SET_COORD: offset_st = 32'(cur - scale_mm(pos_mm));
         default: ;
      endcase
      st.direction      = fwd_st ^ invert_cfg;
      st.moving         = busy_st;
      st.position_steps = abs_pos_st;
      return st;
   endfunction

   // Feedrate that gives roughly the wanted number of ticks between steps.
   function automatic logic [15:0] feed_for_interval(input int unsigned ticks);
      u64_type f;
      if (spm_cfg == 0)
         return 16'd1;
      f = MINUTE_US / (u64_type'(spm_cfg) * (ticks + 1)) + 1;
      if (f > 65535)
         f = 65535;
      return 16'(f);
   endfunction

   // Position in millimetres whose target lies about k steps from the present one.
   function automatic logic [31:0] pos_for_steps(input int k);
      longint tgt;
      longint cur;
      longint off;
      longint spm_l;
      cur   = $signed(abs_pos_st);
      off   = $signed(offset_st);
      spm_l = spm_cfg;
      tgt   = ((cur - off + k) <<< FRACTION_BITS_DEF) / spm_l;
      if (tgt > 64'sd2147483647)
         tgt = 64'sd2147483647;
      if (tgt < -64'sd2147483648)
         tgt = -64'sd2147483648;
      return 32'(tgt);
   endfunction

   // Ticks needed for the loaded move to run out, plus a little slack, capped at MAX_RUN_TICKS.
   function automatic int ticks_to_finish();
      u64_type run;
      run = u64_type'(steps_left_st) * (u64_type'(interval_st) + 1) + $urandom_range(0, 4);
      return (run > MAX_RUN_TICKS) ? MAX_RUN_TICKS : int'(run);
   endfunction

   task automatic send_item(input logic [2:0] cmd, input logic [31:0] count,
                            input logic [15:0] feed, input logic [31:0] pos_mm);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_pulse_count <= count;
      req_feedrate    <= feed;
      req_position_mm <= pos_mm;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      axis_status_q.push_back(advance_axis(cmd, count, feed, pos_mm));
      items_sent++;
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_item(CMD_TICK, $urandom(), 16'($urandom()), $urandom());
   endtask

   // Stops sending and waits until every predicted status has been returned.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (axis_status_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      wait_drained();
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_STEPS_PER_MM)
         spm_cfg = data;
      else
         invert_cfg = data[0];
   endtask

   task automatic test_directed_commands();
      send_item(CMD_TICK, '0, '0, '0);
      send_item(CMD_FORWARD, 32'd5, 16'd0, '0);
      send_item(CMD_MOVE_TO, '0, 16'd0, 32'h7FFF_FFFF);
      send_item(CMD_FORWARD, 32'd0, 16'hFFFF, '0);
      send_item(CMD_BACKWARD, 32'd2, 16'hFFFF, '0);
      send_ticks(12);
      // A new move while one is running keeps the time since the last step.
      send_item(CMD_FORWARD, 32'hFFFF_FFFF, 16'hFFFF, '0);
      send_item(CMD_SET_COORD, '0, '0, 32'h8000_0000);
      send_item(CMD_SET_COORD, '1, '1, 32'h7FFF_FFFF);
      send_item(CMD_MOVE_TO, '0, 16'hFFFF, 32'h8000_0000);
      for (int c = CMD_UNUSED_FIRST; c <= CMD_UNUSED_LAST; c++)
         send_item(3'(c), '1, '1, '1);
   endtask

   task automatic test_register_extremes();
      write_csr(CSR_STEPS_PER_MM, 16'd0);
      write_csr(CSR_INVERT_DIR, 16'hFFFF);
      send_item(CMD_FORWARD, 32'd4, 16'd100, '0);
      send_item(CMD_MOVE_TO, '0, 16'd100, 32'h0000_1000);
      send_item(CMD_TICK, '0, '0, '0);

      write_csr(CSR_STEPS_PER_MM, 16'hFFFF);
      write_csr(CSR_INVERT_DIR, 16'hFFFE);
      send_item(CMD_FORWARD, 32'd3, 16'hFFFF, '0);
      send_ticks(4);
      // Targets at opposite ends of the range drive the step count into saturation.
      send_item(CMD_SET_COORD, '0, '0, 32'h7FFF_FFFF);
      send_item(CMD_MOVE_TO, '0, 16'd1, 32'h8000_0000);
      send_item(CMD_SET_COORD, '0, '0, 32'h8000_0000);
      send_item(CMD_MOVE_TO, '0, 16'd1, 32'h7FFF_FFFF);
      // The coordinate just set scales past the 32-bit offset, so moving back to it is not empty.
      send_item(CMD_SET_COORD, '0, '0, 32'h1234_5678);
      send_item(CMD_MOVE_TO, '0, 16'd10, 32'h1234_5678);
      send_item(CMD_TICK, '0, '0, '0);

      write_csr(CSR_STEPS_PER_MM, 16'd1);
      write_csr(CSR_INVERT_DIR, 16'd1);
      send_item(CMD_BACKWARD, 32'd2, 16'd1, '0);
      send_ticks(3);
      send_item(CMD_MOVE_TO, '0, 16'hFFFF, 32'h0000_0300);
      send_ticks(2);
   endtask

   task automatic test_random_traffic(input int n_items, input logic [15:0] spm,
                                      input logic inv, input bit idling);
      int  goal;
      int  pick;
      int  gap;
      int  k;
      bit  paused;
      write_csr(CSR_STEPS_PER_MM, spm);
      write_csr(CSR_INVERT_DIR, {15'($urandom()), inv});
      idle_on = idling;
      goal    = items_sent + n_items;
      paused  = 1'b0;
      while (items_sent < goal) begin
         if (!paused && items_sent >= goal - n_items / 2) begin
            wait_drained();
            paused = 1'b1;
         end
         pick = $urandom_range(0, 99);
         gap  = $urandom_range(0, 12);
         if (pick < 50) begin
            send_item($urandom_range(0, 1) ? CMD_FORWARD : CMD_BACKWARD,
                      $urandom_range(0, 8), feed_for_interval(gap), $urandom());
            // Now and then the move is cut short by the next one.
            send_ticks($urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : ticks_to_finish());
         end else if (pick < 65) begin
            k = int'($urandom_range(0, 16)) - 8;
            send_item(CMD_MOVE_TO, $urandom(), feed_for_interval(gap), pos_for_steps(k));
            send_ticks(ticks_to_finish());
         end else if (pick < 75) begin
            send_item(CMD_SET_COORD, $urandom(), 16'($urandom()),
                      $urandom_range(0, 3) == 0 ? $urandom() : pos_for_steps(gap - 6));
         end else if (pick < 90) begin
            send_item(3'($urandom_range(0, CMD_UNUSED_LAST)), $urandom(),
                      $urandom_range(0, 7) == 0 ? 16'd0 : 16'($urandom()), $urandom());
         end else begin
            send_ticks($urandom_range(1, 10));
         end
      end
   endtask

   always @(posedge clock) begin : response_checker
      axis_status_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (axis_status_q.size() == 0) begin
               $error("response transaction with no pending prediction");
               fail_count++;
            end else begin
               want = axis_status_q.pop_front();
               if (rsp_step_pulse !== want.step_pulse) begin
                  $error("step_pulse: expected %0d, got %0d", want.step_pulse, rsp_step_pulse);
                  fail_count++;
               end
               if (rsp_direction !== want.direction) begin
                  $error("direction: expected %0d, got %0d", want.direction, rsp_direction);
                  fail_count++;
               end
               if (rsp_moving !== want.moving) begin
                  $error("moving: expected %0d, got %0d", want.moving, rsp_moving);
                  fail_count++;
               end
               if (rsp_position_steps !== want.position_steps) begin
                  $error("position_steps: expected %0d, got %0d",
                         $signed(want.position_steps), rsp_position_steps);
                  fail_count++;
               end
               if (rsp_rejected !== want.rejected) begin
                  $error("rejected: expected %0d, got %0d", want.rejected, rsp_rejected);
                  fail_count++;
               end
            end
         end
         if (stall_left != 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= stall_left - 1;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 14);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Ends the run when no transaction has been taken on either side for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_CYCLES) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      test_directed_commands();
      test_register_extremes();
      test_random_traffic(180, 16'd80, 1'b0, 1'b1);
      test_random_traffic(180, 16'($urandom_range(50, 400)), 1'b1, 1'b1);
      test_random_traffic(180, 16'($urandom_range(400, 4000)), 1'($urandom_range(0, 1)), 1'b1);
      test_random_traffic(140, 16'd160, 1'b0, 1'b0);
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
